>>> rtl/core/der_tlv_stream_walker_macros.svh
// Assertion macros for the DER TLV stream walker.
`ifndef DER_TLV_STREAM_WALKER_MACROS_SVH
`define DER_TLV_STREAM_WALKER_MACROS_SVH
`ifndef SYNTH
`define DTSW_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define DTSW_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define DTSW_ASSERT_IMPL(name, ante, cons)
`define DTSW_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> rtl/core/dtsw_pkg.sv
// Types, codes and helper functions of the DER TLV stream walker.
package dtsw_pkg;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_ARC = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TAG      = 2'd1;
    localparam logic [1:0] ERR_LEN_FORM = 2'd2;
    localparam logic [1:0] ERR_TRUNC    = 2'd3;

    localparam logic [7:0] TAG_OID        = 8'h06;
    localparam int         TAG_CONS_BIT   = 5;
    localparam logic [6:0] MAX_LEN_BYTES  = 7'd4;
    localparam logic [31:0] DIV5_MAGIC    = 32'hCCCCCCCD;

    localparam int SLOT_MAIN  = 0;
    localparam int SLOT_REM   = 1;
    localparam int SLOT_TRUNC = 2;

    typedef enum logic [3:0] {
        PH_TAG  = 4'b0001,
        PH_LEN1 = 4'b0010,
        PH_LENN = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [7:0]  tag;
        logic [2:0]  hlen;
        logic [31:0] blen;
        logic        cons;
        logic [1:0]  kind;
        logic [1:0]  err;
        logic [31:0] arc;
        logic        split;
        logic [2:0]  mask;
    } parse_ev_t;

    function automatic logic tag_ok(input logic [7:0] t);
        logic ok;
        case (t)
            8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h13, 8'h17: ok = 1'b1;
            default: ok = t[TAG_CONS_BIT];
        endcase
        return ok;
    endfunction

endpackage

>>> rtl/core/der_tlv_stream_walker.sv
// Top level of the DER TLV stream walker: byte parser, arc splitter and result sequencer.
// The walker takes one byte of a DER stream per cycle while byte_stall is low and reports,
// per element, a header transaction; object identifier bodies are reported arc by arc, and
// errors end the walk until the byte marked by stream_end. A byte that yields several
// results holds the result port until all have left, since results leave one per cycle
// through the output register while result_stall is low. The first result of a byte
// reaches the result port once it has passed the parse register, the arc split register
// that holds the divide-by-40 multiply, and the output register.
`include "der_tlv_stream_walker_macros.svh"

module der_tlv_stream_walker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [31:0] offset,
    output logic [7:0]  tag,
    output logic [2:0]  header_len,
    output logic [31:0] body_len,
    output logic        constructed,
    output logic [31:0] arc_value,
    output logic [1:0]  error_code,
    output logic        run_last
);

    dtsw_pkg::phase_t phase_reg, phase_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] element_offset_reg, element_offset_next;
    logic [7:0]  current_tag_reg, current_tag_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [2:0]  header_bytes_reg, header_bytes_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [31:0] body_left_reg, body_left_next;
    logic        in_oid_reg, in_oid_next;
    logic [31:0] arc_accum_reg, arc_accum_next;
    logic        first_arc_done_reg, first_arc_done_next;
    logic        halted_reg, halted_next;

    dtsw_pkg::parse_ev_t ev;
    dtsw_pkg::parse_ev_t e1_ev_reg;
    dtsw_pkg::parse_ev_t ser_ev_reg;
    logic        e1_v_reg;
    logic        ser_v_reg;
    logic [2:0]  ser_mask_reg;
    logic [26:0] ser_q_reg;

    logic        byte_acc;
    logic        e1_free;
    logic        ser_free;
    logic        ser_load;
    logic        out_load;
    logic [2:0]  pick;
    logic [2:0]  mask_after;
    logic [60:0] div_prod;
    logic [31:0] q40;
    logic [31:0] rem_full;

    logic        out_v_reg;
    logic [1:0]  kind_reg;
    logic [31:0] offset_reg;
    logic [7:0]  tag_reg;
    logic [2:0]  header_len_reg;
    logic [31:0] body_len_reg;
    logic        constructed_reg;
    logic [31:0] arc_value_reg;
    logic [1:0]  error_code_reg;
    logic        run_last_reg;

    assign out_load   = !out_v_reg || !result_stall;
    assign pick[0]    = ser_mask_reg[0];
    assign pick[1]    = !ser_mask_reg[0] && ser_mask_reg[1];
    assign pick[2]    = !ser_mask_reg[0] && !ser_mask_reg[1] && ser_mask_reg[2];
    assign mask_after = ser_mask_reg & ~pick;
    assign ser_free   = !ser_v_reg || (out_load && (mask_after == 3'b000));
    assign ser_load   = e1_v_reg && ser_free;
    assign e1_free    = !e1_v_reg || ser_load;
    assign byte_stall = !e1_free;
    assign byte_acc   = byte_valid && e1_free;

    always_comb
    begin
        logic        hdr_done;
        logic [6:0]  len_form;
        logic [31:0] arc_new;
        logic [2:0]  len_left_dec;
        hdr_done            = 1'b0;
        len_form            = data_byte[6:0];
        arc_new             = {arc_accum_reg[24:0], data_byte[6:0]};
        len_left_dec        = len_left_reg - 3'd1;
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        element_offset_next = element_offset_reg;
        current_tag_next    = current_tag_reg;
        len_left_next       = len_left_reg;
        header_bytes_next   = header_bytes_reg;
        length_accum_next   = length_accum_reg;
        body_left_next      = body_left_reg;
        in_oid_next         = in_oid_reg;
        arc_accum_next      = arc_accum_reg;
        first_arc_done_next = first_arc_done_reg;
        halted_next         = halted_reg;
        ev                  = '0;

        if (byte_acc)
        begin
            if (!halted_reg)
            begin
                case (phase_reg)
                    dtsw_pkg::PH_TAG:
                    begin
                        element_offset_next = byte_count_reg;
                        current_tag_next    = data_byte;
                        header_bytes_next   = 3'd1;
                        length_accum_next   = '0;
                        if (dtsw_pkg::tag_ok(data_byte))
                        begin
                            phase_next = dtsw_pkg::PH_LEN1;
                        end
                        else
                        begin
                            ev.kind                     = dtsw_pkg::KIND_ERR;
                            ev.err                      = dtsw_pkg::ERR_TAG;
                            ev.mask[dtsw_pkg::SLOT_MAIN] = 1'b1;
                            halted_next                 = 1'b1;
                        end
                    end
                    dtsw_pkg::PH_LEN1:
                    begin
                        header_bytes_next = 3'd2;
                        if (!data_byte[7])
                        begin
                            length_accum_next = {24'd0, data_byte};
                            hdr_done          = 1'b1;
                        end
                        else if (len_form == 7'd0 || len_form > dtsw_pkg::MAX_LEN_BYTES)
                        begin
                            ev.kind                     = dtsw_pkg::KIND_ERR;
                            ev.err                      = dtsw_pkg::ERR_LEN_FORM;
                            ev.mask[dtsw_pkg::SLOT_MAIN] = 1'b1;
                            halted_next                 = 1'b1;
                        end
                        else
                        begin
                            len_left_next = len_form[2:0];
                            phase_next    = dtsw_pkg::PH_LENN;
                        end
                    end
                    dtsw_pkg::PH_LENN:
                    begin
                        length_accum_next = {length_accum_reg[23:0], data_byte};
                        header_bytes_next = header_bytes_reg + 3'd1;
                        len_left_next     = len_left_dec;
                        if (len_left_dec == 3'd0)
                        begin
                            hdr_done = 1'b1;
                        end
                    end
                    dtsw_pkg::PH_BODY:
                    begin
                        if (in_oid_reg)
                        begin
                            arc_accum_next = arc_new;
                            if (!data_byte[7])
                            begin
                                ev.kind                     = dtsw_pkg::KIND_ARC;
                                ev.hlen                     = header_bytes_reg;
                                ev.blen                     = length_accum_reg;
                                ev.arc                      = arc_new;
                                ev.split                    = !first_arc_done_reg;
                                ev.mask[dtsw_pkg::SLOT_MAIN] = 1'b1;
                                ev.mask[dtsw_pkg::SLOT_REM]  = !first_arc_done_reg;
                                first_arc_done_next         = 1'b1;
                                arc_accum_next              = '0;
                            end
                        end
                        body_left_next = body_left_reg - 32'd1;
                        if (body_left_next == 32'd0)
                        begin
                            phase_next          = dtsw_pkg::PH_TAG;
                            in_oid_next         = 1'b0;
                            arc_accum_next      = '0;
                            first_arc_done_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_next = dtsw_pkg::PH_TAG;
                    end
                endcase

                if (hdr_done)
                begin
                    ev.kind                     = dtsw_pkg::KIND_HDR;
                    ev.hlen                     = header_bytes_next;
                    ev.blen                     = length_accum_next;
                    ev.cons                     = current_tag_reg[dtsw_pkg::TAG_CONS_BIT];
                    ev.mask[dtsw_pkg::SLOT_MAIN] = 1'b1;
                    if (current_tag_reg[dtsw_pkg::TAG_CONS_BIT] || length_accum_next == 32'd0)
                    begin
                        phase_next = dtsw_pkg::PH_TAG;
                    end
                    else
                    begin
                        phase_next          = dtsw_pkg::PH_BODY;
                        body_left_next      = length_accum_next;
                        in_oid_next         = (current_tag_reg == dtsw_pkg::TAG_OID);
                        arc_accum_next      = '0;
                        first_arc_done_next = 1'b0;
                    end
                end

                if (stream_end && !halted_next && phase_next != dtsw_pkg::PH_TAG)
                begin
                    ev.mask[dtsw_pkg::SLOT_TRUNC] = 1'b1;
                end
            end

            ev.offset       = element_offset_next;
            ev.tag          = current_tag_next;
            byte_count_next = byte_count_reg + 32'd1;

            if (stream_end)
            begin
                phase_next          = dtsw_pkg::PH_TAG;
                byte_count_next     = '0;
                element_offset_next = '0;
                current_tag_next    = '0;
                len_left_next       = '0;
                header_bytes_next   = '0;
                length_accum_next   = '0;
                body_left_next      = '0;
                in_oid_next         = 1'b0;
                arc_accum_next      = '0;
                first_arc_done_next = 1'b0;
                halted_next         = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= dtsw_pkg::PH_TAG;
            byte_count_reg     <= '0;
            element_offset_reg <= '0;
            current_tag_reg    <= '0;
            len_left_reg       <= '0;
            header_bytes_reg   <= '0;
            length_accum_reg   <= '0;
            body_left_reg      <= '0;
            in_oid_reg         <= 1'b0;
            arc_accum_reg      <= '0;
            first_arc_done_reg <= 1'b0;
            halted_reg         <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            element_offset_reg <= element_offset_next;
            current_tag_reg    <= current_tag_next;
            len_left_reg       <= len_left_next;
            header_bytes_reg   <= header_bytes_next;
            length_accum_reg   <= length_accum_next;
            body_left_reg      <= body_left_next;
            in_oid_reg         <= in_oid_next;
            arc_accum_reg      <= arc_accum_next;
            first_arc_done_reg <= first_arc_done_next;
            halted_reg         <= halted_next;
        end
    end

    // The first arc is split as x / 40 = (x / 8) / 5, with the divide by five done
    // by a reciprocal multiply that is exact for every 32-bit operand.
    assign div_prod = {32'd0, e1_ev_reg.arc[31:3]} * {29'd0, dtsw_pkg::DIV5_MAGIC};
    assign q40      = {ser_q_reg, 5'd0} + {2'd0, ser_q_reg, 3'd0};
    assign rem_full = ser_ev_reg.arc - q40;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg     <= 1'b0;
            ser_v_reg    <= 1'b0;
            ser_mask_reg <= '0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (e1_free)
            begin
                e1_v_reg <= byte_acc && (ev.mask != 3'b000);
            end
            if (ser_load)
            begin
                ser_v_reg    <= 1'b1;
                ser_mask_reg <= e1_ev_reg.mask;
            end
            else if (ser_free)
            begin
                ser_v_reg    <= 1'b0;
                ser_mask_reg <= '0;
            end
            else if (out_load)
            begin
                ser_mask_reg <= mask_after;
            end
            if (out_load)
            begin
                out_v_reg <= ser_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e1_free && byte_acc)
        begin
            e1_ev_reg <= ev;
        end
        if (ser_load)
        begin
            ser_ev_reg <= e1_ev_reg;
            ser_q_reg  <= div_prod[60:34];
        end
        if (out_load && ser_v_reg)
        begin
            offset_reg   <= ser_ev_reg.offset;
            tag_reg      <= ser_ev_reg.tag;
            run_last_reg <= (mask_after == 3'b000);
            if (pick[dtsw_pkg::SLOT_MAIN])
            begin
                kind_reg        <= ser_ev_reg.kind;
                header_len_reg  <= ser_ev_reg.hlen;
                body_len_reg    <= ser_ev_reg.blen;
                constructed_reg <= ser_ev_reg.cons;
                arc_value_reg   <= ser_ev_reg.split ? {5'd0, ser_q_reg} : ser_ev_reg.arc;
                error_code_reg  <= ser_ev_reg.err;
            end
            else if (pick[dtsw_pkg::SLOT_REM])
            begin
                kind_reg        <= dtsw_pkg::KIND_ARC;
                header_len_reg  <= ser_ev_reg.hlen;
                body_len_reg    <= ser_ev_reg.blen;
                constructed_reg <= 1'b0;
                arc_value_reg   <= {26'd0, rem_full[5:0]};
                error_code_reg  <= dtsw_pkg::ERR_NONE;
            end
            else
            begin
                kind_reg        <= dtsw_pkg::KIND_ERR;
                header_len_reg  <= '0;
                body_len_reg    <= '0;
                constructed_reg <= 1'b0;
                arc_value_reg   <= '0;
                error_code_reg  <= dtsw_pkg::ERR_TRUNC;
            end
        end
    end

    assign result_valid = out_v_reg;
    assign kind         = kind_reg;
    assign offset       = offset_reg;
    assign tag          = tag_reg;
    assign header_len   = header_len_reg;
    assign body_len     = body_len_reg;
    assign constructed  = constructed_reg;
    assign arc_value    = arc_value_reg;
    assign error_code   = error_code_reg;
    assign run_last     = run_last_reg;

    `DTSW_ASSERT_NEXT(a_halt_quiet, byte_valid && !byte_stall && halted_reg, !e1_v_reg)
    `DTSW_ASSERT_IMPL(a_ser_pending, ser_v_reg, ser_mask_reg != 3'b000)
    `DTSW_ASSERT_NEXT(a_burst_follows, result_valid && !result_stall && !run_last, result_valid)
    `DTSW_ASSERT_IMPL(a_err_fields, result_valid && kind == dtsw_pkg::KIND_ERR,
        header_len == 3'd0 && body_len == 32'd0 && arc_value == 32'd0)

endmodule

>>> bench/der_tlv_stream_walker_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the DER TLV stream walker, with a byte-level walk predictor.
module der_tlv_stream_walker_test;

    localparam logic [7:0] TAG_INT     = 8'h02;
    localparam logic [7:0] TAG_BITSTR  = 8'h03;
    localparam logic [7:0] TAG_OCTSTR  = 8'h04;
    localparam logic [7:0] TAG_NULL    = 8'h05;
    localparam logic [7:0] TAG_PRTSTR  = 8'h13;
    localparam logic [7:0] TAG_UTCTIME = 8'h17;
    localparam logic [7:0] TAG_SEQ     = 8'h30;
    localparam logic [7:0] TAG_SET     = 8'h31;
    localparam logic [7:0] TAG_BAD     = 8'h00;
    localparam logic [7:0] CONS_FLAG   = 8'h20;
    localparam logic [7:0] LEN_LONG    = 8'h80;
    localparam logic [31:0] ARC_SPLIT  = 32'd40;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_BYTES = 390;

    typedef logic [7:0] octets_t[$];

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] offset;
        logic [7:0]  tag;
        logic [2:0]  hlen;
        logic [31:0] blen;
        logic        cons;
        logic [31:0] arc;
        logic [1:0]  err;
        logic        last;
    } walk_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        stream_end = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [7:0]  tag;
    logic [2:0]  header_len;
    logic [31:0] body_len;
    logic        constructed;
    logic [31:0] arc_value;
    logic [1:0]  error_code;
    logic        run_last;

    der_tlv_stream_walker dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    dtsw_pkg::phase_t walk_phase;
    logic [31:0] byte_pos;
    logic [31:0] elem_offset;
    logic [7:0]  elem_tag;
    logic [2:0]  len_left;
    logic [2:0]  hdr_bytes;
    logic [31:0] len_acc;
    logic [31:0] body_left;
    logic        oid_body;
    logic [31:0] arc_acc;
    logic        first_arc_seen;
    logic        halted;

    walk_result_t step_out[4];
    int           step_n;
    walk_result_t expected_results[$];

    int  fail_count = 0;
    int  bytes_sent = 0;
    int  rx_hold = 0;
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;

    function automatic void clear_walker();
        walk_phase = dtsw_pkg::PH_TAG;
        byte_pos = 0;
        elem_offset = 0;
        elem_tag = 0;
        len_left = 0;
        hdr_bytes = 0;
        len_acc = 0;
        body_left = 0;
        oid_body = 0;
        arc_acc = 0;
        first_arc_seen = 0;
        halted = 0;
    endfunction

    function automatic void note_result(input logic [1:0] k, input logic [2:0] hl,
                                        input logic [31:0] bl, input logic c,
                                        input logic [31:0] arc, input logic [1:0] err);
        step_out[step_n] = '{kind: k, offset: elem_offset, tag: elem_tag, hlen: hl,
                             blen: bl, cons: c, arc: arc, err: err, last: 1'b0};
        step_n++;
    endfunction

    function automatic logic tag_walkable(input logic [7:0] t);
        return t[5] || (t inside {TAG_INT, TAG_BITSTR, TAG_OCTSTR, TAG_NULL,
                                  dtsw_pkg::TAG_OID, TAG_PRTSTR, TAG_UTCTIME});
    endfunction

    function automatic void header_complete();
        logic c;
        c = elem_tag[5];
        note_result(dtsw_pkg::KIND_HDR, hdr_bytes, len_acc, c, 32'd0, dtsw_pkg::ERR_NONE);
        if (c || len_acc == 0)
        begin
            walk_phase = dtsw_pkg::PH_TAG;
        end
        else
        begin
            walk_phase = dtsw_pkg::PH_BODY;
            body_left = len_acc;
            oid_body = (elem_tag == dtsw_pkg::TAG_OID);
            arc_acc = 0;
            first_arc_seen = 0;
        end
    endfunction

    // Advances the walk by one byte and queues the results it produces.
    function automatic void walk_byte(input logic [7:0] b, input logic fin);
        step_n = 0;
        if (!halted)
        begin
            case (walk_phase)
                dtsw_pkg::PH_TAG:
                begin
                    elem_offset = byte_pos;
                    elem_tag = b;
                    hdr_bytes = 3'd1;
                    len_acc = 0;
                    if (tag_walkable(b))
                    begin
                        walk_phase = dtsw_pkg::PH_LEN1;
                    end
                    else
                    begin
                        note_result(dtsw_pkg::KIND_ERR, 3'd0, 32'd0, 1'b0, 32'd0,
                                    dtsw_pkg::ERR_TAG);
                        halted = 1'b1;
                    end
                end
                dtsw_pkg::PH_LEN1:
                begin
                    hdr_bytes = 3'd2;
                    if (!b[7])
                    begin
                        len_acc = {24'd0, b};
                        header_complete();
                    end
                    else if (b[6:0] == 7'd0 || b[6:0] > dtsw_pkg::MAX_LEN_BYTES)
                    begin
                        note_result(dtsw_pkg::KIND_ERR, 3'd0, 32'd0, 1'b0, 32'd0,
                                    dtsw_pkg::ERR_LEN_FORM);
                        halted = 1'b1;
                    end
                    else
                    begin
                        len_left = b[2:0];
                        walk_phase = dtsw_pkg::PH_LENN;
                    end
                end
                dtsw_pkg::PH_LENN:
                begin
                    len_acc = {len_acc[23:0], b};
                    hdr_bytes = hdr_bytes + 3'd1;
                    len_left = len_left - 3'd1;
                    if (len_left == 0)
                        header_complete();
                end
                default:
                begin
                    if (oid_body)
                    begin
                        arc_acc = {arc_acc[24:0], b[6:0]};
                        if (!b[7])
                        begin
                            if (!first_arc_seen)
                            begin
                                note_result(dtsw_pkg::KIND_ARC, hdr_bytes, len_acc, 1'b0,
                                            arc_acc / ARC_SPLIT, dtsw_pkg::ERR_NONE);
                                note_result(dtsw_pkg::KIND_ARC, hdr_bytes, len_acc, 1'b0,
                                            arc_acc % ARC_SPLIT, dtsw_pkg::ERR_NONE);
                                first_arc_seen = 1'b1;
                            end
                            else
                            begin
                                note_result(dtsw_pkg::KIND_ARC, hdr_bytes, len_acc, 1'b0,
                                            arc_acc, dtsw_pkg::ERR_NONE);
                            end
                            arc_acc = 0;
                        end
                    end
                    body_left = body_left - 1;
                    if (body_left == 0)
                    begin
                        walk_phase = dtsw_pkg::PH_TAG;
                        oid_body = 0;
                        arc_acc = 0;
                        first_arc_seen = 0;
                    end
                end
            endcase
            if (fin && !halted && walk_phase != dtsw_pkg::PH_TAG)
                note_result(dtsw_pkg::KIND_ERR, 3'd0, 32'd0, 1'b0, 32'd0,
                            dtsw_pkg::ERR_TRUNC);
        end
        byte_pos = byte_pos + 1;
        for (int i = 0; i < step_n; i++)
        begin
            step_out[i].last = (i == step_n - 1);
            expected_results = {expected_results, step_out[i]};
        end
        if (fin)
            clear_walker();
    endfunction

    function automatic int draw_gap(input logic on);
        return on ? int'($urandom_range(0, 15)) : 0;
    endfunction

    function automatic string fmt_result(input walk_result_t r);
        return $sformatf("kind=%0d off=%0d tag=%h hl=%0d bl=%0d c=%0d arc=%0d err=%0d last=%0d",
                         r.kind, r.offset, r.tag, r.hlen, r.blen, r.cons, r.arc, r.err,
                         r.last);
    endfunction

    always @(posedge clk)
    begin : result_check
        walk_result_t seen;
        walk_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                seen = '{kind: kind, offset: offset, tag: tag, hlen: header_len,
                         blen: body_len, cons: constructed, arc: arc_value,
                         err: error_code, last: run_last};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t unexpected transaction: %s", $time, fmt_result(seen));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t mismatch\n  expected %s\n  actual   %s", $time,
                                     fmt_result(want), fmt_result(seen));
                    end
                end
                rx_hold = draw_gap(rx_idle_on);
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
            end
            result_stall <= (rx_hold > 0);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = draw_gap(tx_idle_on);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= b;
        stream_end <= fin;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        walk_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        byte_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_stream(input octets_t s, input int pause_at);
        for (int i = 0; i < s.size(); i++)
        begin
            if (i == pause_at)
                wait_for_results();
            send_byte(s[i], i == s.size() - 1);
        end
    endtask

    function automatic void put_length(ref octets_t q, input int unsigned n);
        int minimal;
        int k;
        if (n < 128 && $urandom_range(0, 3) != 0)
        begin
            q = {q, 8'(n)};
            return;
        end
        minimal = (n >> 24) != 0 ? 4 : (n >> 16) != 0 ? 3 : (n >> 8) != 0 ? 2 : 1;
        k = int'($urandom_range(minimal, 4));
        q = {q, LEN_LONG | 8'(k)};
        for (int i = k - 1; i >= 0; i--)
            q = {q, 8'(n >> (8 * i))};
    endfunction

    // An over-long arc gets an extra leading group; bits past 32 fall off the accumulator.
    function automatic void put_arc(ref octets_t q, input logic [31:0] v, input logic wide);
        int groups;
        groups = 1;
        while (groups < 5 && (v >> (7 * groups)) != 0)
            groups++;
        if (wide)
            q = {q, 8'h80 | 8'($urandom_range(1, 127))};
        for (int g = groups - 1; g >= 0; g--)
            q = {q, 8'((v >> (7 * g)) & 32'h7F) | (g != 0 ? 8'h80 : 8'h00)};
    endfunction

    function automatic void put_primitive(ref octets_t q);
        logic [7:0] t;
        octets_t body;
        int n;
        case ($urandom_range(0, 6))
            0: t = TAG_INT;
            1: t = TAG_BITSTR;
            2: t = TAG_OCTSTR;
            3: t = TAG_NULL;
            4: t = TAG_PRTSTR;
            5: t = TAG_UTCTIME;
            default: t = dtsw_pkg::TAG_OID;
        endcase
        if (t == dtsw_pkg::TAG_OID)
        begin
            repeat ($urandom_range(0, 4))
                put_arc(body, $urandom_range(0, 1) ? 32'($urandom_range(0, 200)) : $urandom(),
                        $urandom_range(0, 9) == 0);
        end
        else
        begin
            n = ($urandom_range(0, 24) == 0) ? int'($urandom_range(128, 140))
                                             : int'($urandom_range(0, 8));
            repeat (n) body = {body, 8'($urandom)};
        end
        q = {q, t};
        put_length(q, body.size());
        q = {q, body};
    endfunction

    function automatic void put_constructed(ref octets_t q);
        octets_t content;
        octets_t wrapped;
        int levels;
        repeat ($urandom_range(1, 3)) put_primitive(content);
        levels = int'($urandom_range(1, 2));
        for (int lv = 0; lv < levels; lv++)
        begin
            wrapped.delete();
            case ($urandom_range(0, 3))
                0: wrapped = {wrapped, TAG_SEQ};
                1: wrapped = {wrapped, TAG_SET};
                default: wrapped = {wrapped, 8'($urandom) | CONS_FLAG};
            endcase
            put_length(wrapped, content.size());
            wrapped = {wrapped, content};
            content = wrapped;
            if (lv + 1 < levels && $urandom_range(0, 1) != 0)
                put_primitive(content);
        end
        q = {q, content};
    endfunction

    task automatic test_headers();
        octets_t s;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        s = '{TAG_INT, 8'h01, 8'hFF,
              TAG_SEQ, LEN_LONG | 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              TAG_NULL, 8'h00,
              dtsw_pkg::TAG_OID, 8'h03, 8'h2A, 8'h86, 8'h48,
              TAG_UTCTIME, LEN_LONG | 8'h01, 8'h01, 8'h7F};
        send_stream(s, 9);
        wait_for_results();
    endtask

    task automatic test_error_cases();
        octets_t s;
        s = '{TAG_BAD, 8'h55};
        send_stream(s, -1);
        s = '{TAG_OCTSTR, LEN_LONG};
        send_stream(s, -1);
        s = '{TAG_PRTSTR, LEN_LONG | 8'h05};
        send_stream(s, -1);
        s = '{dtsw_pkg::TAG_OID, 8'h03, 8'h2A};
        send_stream(s, -1);
        s = '{dtsw_pkg::TAG_OID, 8'h02, 8'h2B, 8'h81};
        send_stream(s, -1);
        s = '{TAG_BITSTR};
        send_stream(s, -1);
        wait_for_results();
    endtask

    task automatic test_random_streams();
        octets_t s;
        int stream_no;
        int pick;
        int keep;
        int pause_at;
        stream_no = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            s.delete();
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 2) == 0)
                    put_primitive(s);
                else
                    put_constructed(s);
            end
            pick = int'($urandom_range(0, 9));
            if (pick == 7 && s.size() > 1)
            begin
                keep = int'($urandom_range(1, s.size() - 1));
                while (s.size() > keep)
                    void'(s.pop_back());
            end
            else if (pick == 8)
            begin
                s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
            end
            else if (pick == 9)
            begin
                s.delete();
                if ($urandom_range(0, 1) != 0)
                begin
                    s = {s, TAG_OCTSTR};
                    s = {s, LEN_LONG | ($urandom_range(0, 1) ? 8'h00
                                                             : 8'($urandom_range(5, 127)))};
                end
                repeat ($urandom_range(1, 6)) s = {s, 8'($urandom)};
            end
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            pause_at = (stream_no == 3 && s.size() > 2) ? s.size() / 2 : -1;
            send_stream(s, pause_at);
            stream_no++;
        end
        wait_for_results();
    endtask

    initial
    begin
        clear_walker();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_headers();
        test_error_cases();
        test_random_streams();
        if (fail_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
